FILE: src/tps_pkg.sv
// ----------------------------------------------------------------------------
// Triangle plane splitter package
// Shared types and constants for the splitter core and its sub-units.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int unsigned MaxTriangles = 4096;
  localparam int unsigned MemoDepth    = 4096;
  localparam int unsigned MemoAw       = $clog2(MemoDepth);
  localparam int unsigned CoordW       = 32;
  localparam int unsigned CountW       = 13;
  localparam int unsigned IndexW       = 12;
  localparam int unsigned KindW        = 3;
  localparam int unsigned MagW         = CoordW + 1;
  localparam int unsigned ProdW        = 2 * MagW;
  localparam int unsigned StepW        = $clog2(ProdW + 1);

  typedef logic [2:0][CoordW-1:0] vec_t;

  typedef enum logic [KindW-1:0] {
    KIND_NEW_LOW   = 3'd0,
    KIND_NEW_HIGH  = 3'd1,
    KIND_MEMO_LOW  = 3'd2,
    KIND_MEMO_HIGH = 3'd3,
    KIND_NO_CROSS  = 3'd4,
    KIND_OVERFLOW  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_W = 2'd3
  } axis_e;

  typedef enum logic [1:0] {
    MODE_SPLIT,
    MODE_REPLAY,
    MODE_NO_CROSS,
    MODE_OVERFLOW
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } core_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_e;

  typedef struct packed {
    logic              valid;
    logic              lone_low;
    logic [IndexW-1:0] base;
  } memo_entry_t;

  typedef struct packed {
    logic                   start;
    logic signed [MagW-1:0] d;
    logic signed [MagW-1:0] h;
    logic signed [MagW-1:0] a;
  } md_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [MagW:0]   q;
  } md_rsp_t;

endpackage

FILE: src/tps_memo.sv
// ----------------------------------------------------------------------------
// Split memo memory
// One write port and one registered read port, indexed by triangle.
// ----------------------------------------------------------------------------
module tps_memo (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [tps_pkg::MemoAw-1:0] waddr_i,
  input  tps_pkg::memo_entry_t       wdata_i,
  input  logic                       re_i,
  input  logic [tps_pkg::MemoAw-1:0] raddr_i,
  output tps_pkg::memo_entry_t       rdata_o
);

  tps_pkg::memo_entry_t mem [tps_pkg::MemoDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: src/tps_muldiv.sv
// ----------------------------------------------------------------------------
// Scaled quotient unit
// Computes (d * h) / a truncated toward zero with a bit-serial multiply
// followed by a bit-serial restoring division.
// ----------------------------------------------------------------------------
module tps_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tps_pkg::md_req_t req_i,
  output tps_pkg::md_rsp_t rsp_o
);

  localparam int unsigned MagW  = tps_pkg::MagW;
  localparam int unsigned ProdW = tps_pkg::ProdW;
  localparam int unsigned StepW = tps_pkg::StepW;

  tps_pkg::md_state_e state_q, state_d;
  logic [StepW-1:0]   step_q;
  logic [ProdW-1:0]   acc_q;
  logic [MagW-1:0]    x_q;
  logic [MagW-1:0]    div_q;
  logic [MagW-1:0]    rem_q;
  logic               neg_q;

  logic [MagW:0]      mul_sum;
  logic [MagW:0]      rem_sh;
  logic               q_bit;
  logic [MagW:0]      q_ext;

  function automatic logic [MagW-1:0] mag(input logic signed [MagW-1:0] v);
    mag = v[MagW-1] ? MagW'(-v) : MagW'(v);
  endfunction

  assign mul_sum = {1'b0, acc_q[ProdW-1:MagW]} + {1'b0, x_q};
  assign rem_sh  = {rem_q, acc_q[ProdW-1]};
  assign q_bit   = rem_sh >= {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      tps_pkg::MD_IDLE: if (req_i.start) state_d = tps_pkg::MD_MUL;
      tps_pkg::MD_MUL:  if (step_q == StepW'(MagW - 1)) state_d = tps_pkg::MD_DIV;
      tps_pkg::MD_DIV:  if (step_q == StepW'(ProdW - 1)) state_d = tps_pkg::MD_DONE;
      tps_pkg::MD_DONE: state_d = tps_pkg::MD_IDLE;
      default:          state_d = tps_pkg::MD_IDLE;
    endcase
  end

  always_comb begin
    q_ext = {1'b0, acc_q[MagW-1:0]};
    rsp_o.done = (state_q == tps_pkg::MD_DONE);
    if (div_q == '0) begin
      rsp_o.q = '0;
    end else if (neg_q) begin
      rsp_o.q = -$signed(q_ext);
    end else begin
      rsp_o.q = $signed(q_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tps_pkg::MD_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) begin
        step_q <= '0;
      end else begin
        step_q <= step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tps_pkg::MD_IDLE: begin
        if (req_i.start) begin
          x_q   <= mag(req_i.d);
          div_q <= mag(req_i.a);
          acc_q <= {{(ProdW - MagW){1'b0}}, mag(req_i.h)};
          rem_q <= '0;
          neg_q <= req_i.d[MagW-1] ^ req_i.h[MagW-1] ^ req_i.a[MagW-1];
        end
      end
      tps_pkg::MD_MUL: begin
        if (acc_q[0]) begin
          acc_q <= {mul_sum, acc_q[MagW-1:1]};
        end else begin
          acc_q <= {1'b0, acc_q[ProdW-1:1]};
        end
      end
      tps_pkg::MD_DIV: begin
        acc_q <= {acc_q[ProdW-2:0], q_bit};
        if (q_bit) begin
          rem_q <= MagW'(rem_sh - {1'b0, div_q});
        end else begin
          rem_q <= rem_sh[MagW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/triangle_plane_splitter_core.sv
// ----------------------------------------------------------------------------
// Triangle plane splitter core
// Cuts a triangle by an axis-aligned plane and replays earlier splits.
// ----------------------------------------------------------------------------
// Each input transaction carries a triangle, an axis and a plane height over
// a valid/ready channel. Each input yields one or three output transactions,
// with last_piece_o marking the final one. The block takes one input at a
// time: in_ready_o is high only while it is idle.
// A memo replay, a triangle the plane misses and an index overflow each go
// from idle through the lookup state to the emit state. A new split runs six
// cut points in turn through one shared bit-serial unit (a start step, the
// multiply steps, the divide steps and a done step per point) before the
// first piece can be taken.
// Results then leave at one per cycle while the receiver takes them; when
// out_ready_i is low the current result holds and nothing advances.
// After reset the block clears the 4096-entry memo, one entry per cycle, and
// accepts no input until the clear is done. The user writes the configuration
// register through cfg_we_i and cfg_wdata_i only while no transaction is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module triangle_plane_splitter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tps_pkg::CountW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          axis_select_i,
  input  logic signed [tps_pkg::CoordW-1:0]   plane_height_i,
  input  logic [tps_pkg::IndexW-1:0]          source_index_i,
  input  logic signed [tps_pkg::CoordW-1:0]   v0_x_i,
  input  logic signed [tps_pkg::CoordW-1:0]   v0_y_i,
  input  logic signed [tps_pkg::CoordW-1:0]   v0_z_i,
  input  logic signed [tps_pkg::CoordW-1:0]   v1_x_i,
  input  logic signed [tps_pkg::CoordW-1:0]   v1_y_i,
  input  logic signed [tps_pkg::CoordW-1:0]   v1_z_i,
  input  logic signed [tps_pkg::CoordW-1:0]   v2_x_i,
  input  logic signed [tps_pkg::CoordW-1:0]   v2_y_i,
  input  logic signed [tps_pkg::CoordW-1:0]   v2_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tps_pkg::KindW-1:0]           kind_o,
  output logic [tps_pkg::IndexW-1:0]          tri_index_o,
  output logic signed [tps_pkg::CoordW-1:0]   p0_x_o,
  output logic signed [tps_pkg::CoordW-1:0]   p0_y_o,
  output logic signed [tps_pkg::CoordW-1:0]   p0_z_o,
  output logic signed [tps_pkg::CoordW-1:0]   p1_x_o,
  output logic signed [tps_pkg::CoordW-1:0]   p1_y_o,
  output logic signed [tps_pkg::CoordW-1:0]   p1_z_o,
  output logic signed [tps_pkg::CoordW-1:0]   p2_x_o,
  output logic signed [tps_pkg::CoordW-1:0]   p2_y_o,
  output logic signed [tps_pkg::CoordW-1:0]   p2_z_o,
  output logic                                last_piece_o
);

  localparam int unsigned CoordW = tps_pkg::CoordW;
  localparam int unsigned MagW   = tps_pkg::MagW;
  localparam int unsigned IndexW = tps_pkg::IndexW;
  localparam int unsigned CountW = tps_pkg::CountW;
  localparam int unsigned MemoAw = tps_pkg::MemoAw;

  tps_pkg::core_state_e state_q, state_d;
  logic [CountW-1:0]    itc_q;
  logic [CountW-1:0]    added_q;
  logic [MemoAw-1:0]    clr_q;

  logic [1:0]           axis_q;
  logic [CoordW-1:0]    plane_q;
  logic [IndexW-1:0]    src_q;
  tps_pkg::vec_t [2:0]  vtx_q;
  tps_pkg::vec_t        lone_q;
  tps_pkg::vec_t [1:0]  pop_q;
  tps_pkg::vec_t [1:0]  hit_q;
  logic [MagW-1:0]      h_q;
  logic [1:0][MagW-1:0] a_q;
  logic                 hp_q;
  logic [1:0]           hc_q;
  tps_pkg::mode_e       mode_q;
  logic                 lone_low_q;
  logic [IndexW-1:0]    base_q;
  logic [1:0]           piece_q;

  logic                 in_fire;
  logic                 out_fire;
  logic                 last_hit;
  logic                 last_out;
  logic [2:0]           low;
  logic [1:0]           low_count;
  logic                 lone_low;
  logic                 no_cross;
  logic [CountW:0]      next_idx;
  logic                 overflow;
  logic [1:0]           lone_sel;
  tps_pkg::vec_t        lone_v;
  tps_pkg::vec_t        pop0_v;
  tps_pkg::vec_t        pop1_v;

  logic                 mem_we;
  logic [MemoAw-1:0]    mem_waddr;
  tps_pkg::memo_entry_t mem_wdata;
  tps_pkg::memo_entry_t mem_rdata;
  tps_pkg::md_req_t     md_req;
  tps_pkg::md_rsp_t     md_rsp;

  function automatic logic [MagW-1:0] sx(input logic [CoordW-1:0] v);
    sx = {v[CoordW-1], v};
  endfunction

  assign in_ready_o = (state_q == tps_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;
  assign last_hit   = hp_q && (hc_q == 2'd2);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      low[i] = $signed(vtx_q[i][axis_q]) <= $signed(plane_q);
    end
    low_count = 2'(low[0]) + 2'(low[1]) + 2'(low[2]);
    no_cross  = (low == 3'b000) || (low == 3'b111);
    lone_low  = (low_count == 2'd1);
    next_idx  = {1'b0, itc_q} + {1'b0, added_q};
    overflow  = ({1'b0, next_idx} + (CountW + 2)'(3)) >
                (CountW + 2)'(tps_pkg::MaxTriangles);
    if (low[0] == lone_low) begin
      lone_sel = 2'd0;
    end else if (low[1] == lone_low) begin
      lone_sel = 2'd1;
    end else begin
      lone_sel = 2'd2;
    end
    case (lone_sel)
      2'd0: begin
        lone_v = vtx_q[0];
        pop0_v = vtx_q[1];
        pop1_v = vtx_q[2];
      end
      2'd1: begin
        lone_v = vtx_q[1];
        pop0_v = vtx_q[0];
        pop1_v = vtx_q[2];
      end
      default: begin
        lone_v = vtx_q[2];
        pop0_v = vtx_q[0];
        pop1_v = vtx_q[1];
      end
    endcase
  end

  always_comb begin
    md_req.start = (state_q == tps_pkg::ST_START);
    md_req.d     = $signed(sx(pop_q[hp_q][hc_q]) - sx(lone_q[hc_q]));
    md_req.h     = $signed(h_q);
    md_req.a     = $signed(a_q[hp_q]);
  end

  tps_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = src_q;
    mem_wdata = '0;
    if (state_q == tps_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (state_q == tps_pkg::ST_WAIT && md_rsp.done && last_hit) begin
      mem_we             = 1'b1;
      mem_wdata.valid    = 1'b1;
      mem_wdata.lone_low = lone_low_q;
      mem_wdata.base     = base_q;
    end
  end

  tps_memo u_memo (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_fire),
    .raddr_i (source_index_i),
    .rdata_o (mem_rdata)
  );

  assign last_out = (mode_q != tps_pkg::MODE_SPLIT && mode_q != tps_pkg::MODE_REPLAY) ||
                    (piece_q == 2'd2);

  always_comb begin
    state_d = state_q;
    case (state_q)
      tps_pkg::ST_CLEAR: begin
        if (clr_q == MemoAw'(tps_pkg::MemoDepth - 1)) state_d = tps_pkg::ST_IDLE;
      end
      tps_pkg::ST_IDLE: begin
        if (in_fire) state_d = tps_pkg::ST_LOOKUP;
      end
      tps_pkg::ST_LOOKUP: begin
        if (mem_rdata.valid || no_cross || overflow) begin
          state_d = tps_pkg::ST_EMIT;
        end else begin
          state_d = tps_pkg::ST_START;
        end
      end
      tps_pkg::ST_START: state_d = tps_pkg::ST_WAIT;
      tps_pkg::ST_WAIT: begin
        if (md_rsp.done) begin
          state_d = last_hit ? tps_pkg::ST_EMIT : tps_pkg::ST_START;
        end
      end
      tps_pkg::ST_EMIT: begin
        if (out_fire && last_out) state_d = tps_pkg::ST_IDLE;
      end
      default: state_d = tps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_o  = (state_q == tps_pkg::ST_EMIT);
    last_piece_o = last_out;
    kind_o       = tps_pkg::KIND_NO_CROSS;
    tri_index_o  = '0;
    {p0_x_o, p0_y_o, p0_z_o} = '0;
    {p1_x_o, p1_y_o, p1_z_o} = '0;
    {p2_x_o, p2_y_o, p2_z_o} = '0;
    case (mode_q)
      tps_pkg::MODE_SPLIT: begin
        case (piece_q)
          2'd0: begin
            kind_o      = lone_low_q ? tps_pkg::KIND_NEW_LOW : tps_pkg::KIND_NEW_HIGH;
            tri_index_o = base_q;
            {p0_z_o, p0_y_o, p0_x_o} = lone_q;
            {p1_z_o, p1_y_o, p1_x_o} = hit_q[0];
            {p2_z_o, p2_y_o, p2_x_o} = hit_q[1];
          end
          2'd1: begin
            kind_o      = lone_low_q ? tps_pkg::KIND_NEW_HIGH : tps_pkg::KIND_NEW_LOW;
            tri_index_o = base_q + IndexW'(1);
            {p0_z_o, p0_y_o, p0_x_o} = hit_q[0];
            {p1_z_o, p1_y_o, p1_x_o} = pop_q[0];
            {p2_z_o, p2_y_o, p2_x_o} = hit_q[1];
          end
          default: begin
            kind_o      = lone_low_q ? tps_pkg::KIND_NEW_HIGH : tps_pkg::KIND_NEW_LOW;
            tri_index_o = base_q + IndexW'(2);
            {p0_z_o, p0_y_o, p0_x_o} = hit_q[1];
            {p1_z_o, p1_y_o, p1_x_o} = pop_q[0];
            {p2_z_o, p2_y_o, p2_x_o} = pop_q[1];
          end
        endcase
      end
      tps_pkg::MODE_REPLAY: begin
        case (piece_q)
          2'd0: begin
            kind_o      = tps_pkg::KIND_MEMO_LOW;
            tri_index_o = lone_low_q ? base_q : base_q + IndexW'(1);
          end
          2'd1: begin
            kind_o      = lone_low_q ? tps_pkg::KIND_MEMO_HIGH : tps_pkg::KIND_MEMO_LOW;
            tri_index_o = lone_low_q ? base_q + IndexW'(1) : base_q + IndexW'(2);
          end
          default: begin
            kind_o      = tps_pkg::KIND_MEMO_HIGH;
            tri_index_o = lone_low_q ? base_q + IndexW'(2) : base_q;
          end
        endcase
      end
      tps_pkg::MODE_OVERFLOW: kind_o = tps_pkg::KIND_OVERFLOW;
      default:                kind_o = tps_pkg::KIND_NO_CROSS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tps_pkg::ST_CLEAR;
      itc_q   <= '0;
      added_q <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        itc_q <= cfg_wdata_i;
      end
      if (state_q == tps_pkg::ST_CLEAR) begin
        clr_q <= clr_q + MemoAw'(1);
      end
      if (state_q == tps_pkg::ST_WAIT && md_rsp.done && last_hit) begin
        added_q <= added_q + CountW'(3);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tps_pkg::ST_IDLE: begin
        if (in_fire) begin
          axis_q   <= (axis_select_i == tps_pkg::AXIS_W) ? tps_pkg::AXIS_Z : axis_select_i;
          plane_q  <= plane_height_i;
          src_q    <= source_index_i;
          vtx_q[0] <= {v0_z_i, v0_y_i, v0_x_i};
          vtx_q[1] <= {v1_z_i, v1_y_i, v1_x_i};
          vtx_q[2] <= {v2_z_i, v2_y_i, v2_x_i};
        end
      end
      tps_pkg::ST_LOOKUP: begin
        piece_q <= '0;
        hp_q    <= 1'b0;
        hc_q    <= '0;
        lone_q  <= lone_v;
        pop_q   <= {pop1_v, pop0_v};
        h_q     <= sx(plane_q) - sx(lone_v[axis_q]);
        a_q[0]  <= sx(pop0_v[axis_q]) - sx(lone_v[axis_q]);
        a_q[1]  <= sx(pop1_v[axis_q]) - sx(lone_v[axis_q]);
        if (mem_rdata.valid) begin
          mode_q     <= tps_pkg::MODE_REPLAY;
          lone_low_q <= mem_rdata.lone_low;
          base_q     <= mem_rdata.base;
        end else begin
          lone_low_q <= lone_low;
          base_q     <= next_idx[IndexW-1:0];
          if (no_cross) begin
            mode_q <= tps_pkg::MODE_NO_CROSS;
          end else if (overflow) begin
            mode_q <= tps_pkg::MODE_OVERFLOW;
          end else begin
            mode_q <= tps_pkg::MODE_SPLIT;
          end
        end
      end
      tps_pkg::ST_WAIT: begin
        if (md_rsp.done) begin
          hit_q[hp_q][hc_q] <= lone_q[hc_q] + md_rsp.q[CoordW-1:0];
          if (hc_q == 2'd2) begin
            hc_q <= '0;
            hp_q <= 1'b1;
          end else begin
            hc_q <= hc_q + 2'd1;
          end
        end
      end
      tps_pkg::ST_EMIT: begin
        if (out_fire) begin
          piece_q <= piece_q + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/tps_checker.sv
// ----------------------------------------------------------------------------
// Triangle plane splitter port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module tps_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [tps_pkg::KindW-1:0]         kind_o,
  input logic [tps_pkg::IndexW-1:0]        tri_index_o,
  input logic                              last_piece_o
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(tri_index_o) && $stable(last_piece_o))
    else $error("Output transaction changed while stalled.");

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input accepted twice in a row.");

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("Input ready while results are pending.");

  a_single_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == tps_pkg::KIND_NO_CROSS || kind_o == tps_pkg::KIND_OVERFLOW)
    |-> last_piece_o && tri_index_o == '0)
    else $error("Single-result transaction is malformed.");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_piece_o |=> !out_valid_o && in_ready_o)
    else $error("Block did not return to idle after the last result.");

endmodule

bind triangle_plane_splitter_core tps_checker u_tps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_o       (kind_o),
  .tri_index_o  (tri_index_o),
  .last_piece_o (last_piece_o)
);

FILE: verif/triangle_plane_splitter_checker.sv
// ----------------------------------------------------------------------------
// Triangle plane splitter checker
// Watches the configuration, input and output channels of the splitter core.
// It keeps its own copy of the split memo and the index counter, and works
// out the pieces, replays or flags that each accepted triangle must produce.
// Every result transaction is compared field by field with the oldest
// expected one.
// ----------------------------------------------------------------------------
module triangle_plane_splitter_checker
  import tps_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CountW-1:0]             cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    axis_i,
  input  logic signed [CoordW-1:0]      plane_i,
  input  logic [IndexW-1:0]             src_i,
  input  logic [2:0][2:0][CoordW-1:0]   vert_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [KindW-1:0]              kind_i,
  input  logic [IndexW-1:0]             tri_index_i,
  input  logic [2:0][2:0][CoordW-1:0]   piece_i,
  input  logic                          last_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            added_o,
  output int                            inputs_o,
  output int                            results_o,
  output int                            splits_o,
  output int                            replays_o
);

  typedef logic [2:0][2:0][CoordW-1:0] corners_t;

  typedef struct {
    kind_e             kind;
    logic [IndexW-1:0] index;
    corners_t          corners;
    logic              last;
  } piece_t;

  logic              memo_valid [MemoDepth];
  logic              memo_low   [MemoDepth];
  logic [IndexW-1:0] memo_base  [MemoDepth];
  logic [CountW-1:0] start_count;
  logic [CountW:0]   added;
  piece_t            expected_pieces[$];
  int                fails, n_in, n_out, n_split, n_replay;
  string             coord_name[3] = '{"x", "y", "z"};

  assign fail_count_o = fails;
  assign pending_o    = expected_pieces.size();
  assign added_o      = int'(added);
  assign inputs_o     = n_in;
  assign results_o    = n_out;
  assign splits_o     = n_split;
  assign replays_o    = n_replay;

  function automatic longint cut_offset(longint d, longint h, longint a);
    logic [127:0] prod;
    logic [127:0] quot;
    logic [63:0]  md, mh, ma;
    bit           neg;
    md = (d < 0) ? -d : d;
    mh = (h < 0) ? -h : h;
    ma = (a < 0) ? -a : a;
    if (ma == 0) return 0;
    prod = {64'd0, md} * {64'd0, mh};
    quot = prod / {64'd0, ma};
    neg  = ((d < 0) != (h < 0)) != (a < 0);
    return neg ? -longint'(quot[63:0]) : longint'(quot[63:0]);
  endfunction

  task automatic push_piece(kind_e k, logic [IndexW-1:0] idx, corners_t c, logic last);
    piece_t p;
    p.kind    = k;
    p.index   = idx;
    p.corners = c;
    p.last    = last;
    expected_pieces = {expected_pieces, p};
  endtask

  task automatic predict_cut(logic [1:0] axis, logic signed [CoordW-1:0] plane,
                             logic [IndexW-1:0] src, corners_t vert);
    int              ax, cnt, lone, np;
    int              pop[2];
    bit              low[3];
    bit              lone_low;
    logic [CountW:0] nxt;
    longint          lc[3];
    longint          hit[2][3];
    longint          a, h;
    corners_t        c0, c1, c2;
    ax = (axis == AXIS_W) ? 2 : int'(axis);
    if (memo_valid[src]) begin
      n_replay++;
      if (memo_low[src]) begin
        push_piece(KIND_MEMO_LOW, memo_base[src], '0, 1'b0);
        push_piece(KIND_MEMO_HIGH, memo_base[src] + IndexW'(1), '0, 1'b0);
        push_piece(KIND_MEMO_HIGH, memo_base[src] + IndexW'(2), '0, 1'b1);
      end else begin
        push_piece(KIND_MEMO_LOW, memo_base[src] + IndexW'(1), '0, 1'b0);
        push_piece(KIND_MEMO_LOW, memo_base[src] + IndexW'(2), '0, 1'b0);
        push_piece(KIND_MEMO_HIGH, memo_base[src], '0, 1'b1);
      end
      return;
    end
    cnt = 0;
    for (int i = 0; i < 3; i++) begin
      low[i] = $signed(vert[i][ax]) <= plane;
      cnt += low[i];
    end
    if (cnt == 0 || cnt == 3) begin
      push_piece(KIND_NO_CROSS, '0, '0, 1'b1);
      return;
    end
    nxt = start_count + added;
    if (nxt + 3 > MaxTriangles) begin
      push_piece(KIND_OVERFLOW, '0, '0, 1'b1);
      return;
    end
    lone_low = (cnt == 1);
    lone = 0;
    np = 0;
    for (int i = 0; i < 3; i++) begin
      if (low[i] == lone_low) lone = i;
      else begin
        pop[np] = i;
        np++;
      end
    end
    for (int j = 0; j < 3; j++) lc[j] = longint'($signed(vert[lone][j]));
    h = longint'(plane) - lc[ax];
    for (int k = 0; k < 2; k++) begin
      a = longint'($signed(vert[pop[k]][ax])) - lc[ax];
      for (int j = 0; j < 3; j++)
        hit[k][j] = lc[j] + cut_offset(longint'($signed(vert[pop[k]][j])) - lc[j], h, a);
    end
    for (int j = 0; j < 3; j++) begin
      c0[0][j] = vert[lone][j];
      c0[1][j] = hit[0][j][CoordW-1:0];
      c0[2][j] = hit[1][j][CoordW-1:0];
      c1[0][j] = hit[0][j][CoordW-1:0];
      c1[1][j] = vert[pop[0]][j];
      c1[2][j] = hit[1][j][CoordW-1:0];
      c2[0][j] = hit[1][j][CoordW-1:0];
      c2[1][j] = vert[pop[0]][j];
      c2[2][j] = vert[pop[1]][j];
    end
    push_piece(lone_low ? KIND_NEW_LOW : KIND_NEW_HIGH, nxt[IndexW-1:0], c0, 1'b0);
    push_piece(lone_low ? KIND_NEW_HIGH : KIND_NEW_LOW, nxt[IndexW-1:0] + IndexW'(1),
               c1, 1'b0);
    push_piece(lone_low ? KIND_NEW_HIGH : KIND_NEW_LOW, nxt[IndexW-1:0] + IndexW'(2),
               c2, 1'b1);
    memo_valid[src] = 1'b1;
    memo_low[src]   = lone_low;
    memo_base[src]  = nxt[IndexW-1:0];
    added += 3;
    n_split++;
  endtask

  task automatic check_field(string name, logic [CoordW-1:0] exp_v, logic [CoordW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    piece_t p;
    if (!rst_ni) begin
      for (int i = 0; i < MemoDepth; i++) begin
        memo_valid[i] = 1'b0;
        memo_low[i]   = 1'b0;
        memo_base[i]  = '0;
      end
      start_count = '0;
      added       = '0;
      expected_pieces.delete();
      fails    = 0;
      n_in     = 0;
      n_out    = 0;
      n_split  = 0;
      n_replay = 0;
    end else begin
      if (cfg_we_i) start_count = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        n_out++;
        if (expected_pieces.size() == 0) begin
          $error("Unexpected result transaction, kind %0d index %0d", kind_i, tri_index_i);
          fails++;
        end else begin
          p = expected_pieces.pop_front();
          check_field("kind", 32'(p.kind), 32'(kind_i));
          check_field("tri_index", 32'(p.index), 32'(tri_index_i));
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
              check_field($sformatf("p%0d_%s", i, coord_name[j]), p.corners[i][j],
                          piece_i[i][j]);
          check_field("last_piece", 32'(p.last), 32'(last_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        n_in++;
        predict_cut(axis_i, plane_i, src_i, vert_i);
      end
    end
  end

endmodule

FILE: verif/triangle_plane_splitter_core_test.sv
// ----------------------------------------------------------------------------
// Triangle plane splitter core testbench
// Drives directed and random triangles into the splitter core through bursty
// input traffic and a stalling receiver, over several settings of the initial
// triangle count, and lets the checker judge every result transaction.
// ----------------------------------------------------------------------------
module triangle_plane_splitter_core_test;
  import tps_pkg::*;

  typedef struct {
    logic [1:0]                 axis;
    logic signed [CoordW-1:0]   plane;
    logic [IndexW-1:0]          src;
    logic [2:0][2:0][CoordW-1:0] vert;
  } tri_job_t;

  localparam logic [31:0] CMin = 32'h8000_0000;
  localparam logic [31:0] CMax = 32'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CountW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] axis_sel = '0;
  logic signed [CoordW-1:0] plane = '0;
  logic [IndexW-1:0] src = '0;
  logic [2:0][2:0][CoordW-1:0] vert = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KindW-1:0] kind;
  logic [IndexW-1:0] tri_index;
  logic [2:0][2:0][CoordW-1:0] piece;
  logic last_piece;
  int fail_count, pending, added, n_in, n_out, n_split, n_replay;
  int burst_left = 0;
  int rx_mode = 0;
  int rx_left = 0;

  always #2 clk = ~clk;

  triangle_plane_splitter_core uut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .axis_select_i(axis_sel),
    .plane_height_i(plane), .source_index_i(src),
    .v0_x_i(vert[0][0]), .v0_y_i(vert[0][1]), .v0_z_i(vert[0][2]),
    .v1_x_i(vert[1][0]), .v1_y_i(vert[1][1]), .v1_z_i(vert[1][2]),
    .v2_x_i(vert[2][0]), .v2_y_i(vert[2][1]), .v2_z_i(vert[2][2]),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .kind_o(kind),
    .tri_index_o(tri_index),
    .p0_x_o(piece[0][0]), .p0_y_o(piece[0][1]), .p0_z_o(piece[0][2]),
    .p1_x_o(piece[1][0]), .p1_y_o(piece[1][1]), .p1_z_o(piece[1][2]),
    .p2_x_o(piece[2][0]), .p2_y_o(piece[2][1]), .p2_z_o(piece[2][2]),
    .last_piece_o(last_piece)
  );

  triangle_plane_splitter_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .axis_i(axis_sel),
    .plane_i(plane), .src_i(src), .vert_i(vert),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .kind_i(kind),
    .tri_index_i(tri_index), .piece_i(piece), .last_i(last_piece),
    .fail_count_o(fail_count), .pending_o(pending), .added_o(added),
    .inputs_o(n_in), .results_o(n_out), .splits_o(n_split), .replays_o(n_replay)
  );

  always_ff @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_mode   <= 0;
      rx_left   <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(20, 400);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  function automatic tri_job_t mk_job(logic [1:0] ax, logic [31:0] pl, logic [11:0] s,
                                      logic [31:0] c[9]);
    tri_job_t j;
    j.axis  = ax;
    j.plane = pl;
    j.src   = s;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) j.vert[i][k] = c[3 * i + k];
    return j;
  endfunction

  task automatic send_job(tri_job_t j);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    axis_sel <= j.axis;
    plane    <= j.plane;
    src      <= j.src;
    vert     <= j.vert;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(logic [CountW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic rand_job(output tri_job_t j, input bit fresh);
    int     style, ax;
    longint lo, hi, c;
    style = $urandom_range(0, 9);
    j.axis = 2'($urandom_range(0, 3));
    ax = (j.axis == AXIS_W) ? 2 : int'(j.axis);
    j.src = (!fresh && $urandom_range(0, 1)) ? IndexW'($urandom_range(0, 47)) :
                                                IndexW'($urandom_range(0, 4095));
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        j.vert[i][k] = ($urandom_range(0, 2) == 0) ? 32'($signed(21'($urandom))) : $urandom;
    j.plane = $urandom;
    if (style == 0) return;
    lo = longint'($signed(j.vert[0][ax]));
    hi = lo;
    for (int i = 1; i < 3; i++) begin
      c = longint'($signed(j.vert[i][ax]));
      if (c < lo) lo = c;
      if (c > hi) hi = c;
    end
    if (style == 1) begin
      if ($urandom_range(0, 1) && lo > -64'sd2147483648) j.plane = 32'(lo - 1);
      else j.plane = 32'(hi);
    end else if (hi > lo) begin
      j.plane = 32'(lo + longint'({$urandom, $urandom} % 64'(hi - lo)));
    end
  endtask

  task automatic run_random(int count, bit fresh);
    tri_job_t j;
    for (int n = 0; n < count; n++) begin
      rand_job(j, fresh);
      send_job(j);
    end
  endtask

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_count('0);

    send_job(mk_job(AXIS_X, CMax, 12'd0,
             '{CMin, CMin, CMin, CMin, CMin, CMin, CMin, CMin, CMin}));
    send_job(mk_job(AXIS_Y, CMin, 12'd0,
             '{CMax, CMax, CMax, CMax, CMax, CMax, CMax, CMax, CMax}));
    send_job(mk_job(AXIS_X, 32'h0, 12'd1,
             '{CMin, CMax, CMin, CMax, CMin, CMax, CMax, CMax, CMin}));
    send_job(mk_job(AXIS_Y, 32'h0001_0000, 12'd2,
             '{32'h0, CMin, 32'h5, 32'h0003_0000, CMax, 32'hFFFF_0000,
               32'hFFFE_8000, CMin, 32'h7}));
    send_job(mk_job(AXIS_Z, 32'hFFFF_8000, 12'd3,
             '{32'h1, 32'h2, CMax, 32'hFFFF_FFFF, 32'h4, 32'h0010_0000,
               CMax, CMin, CMin}));
    send_job(mk_job(AXIS_W, 32'h0000_0100, 12'd4,
             '{CMax, CMin, CMax, 32'h0123_4567, 32'hFEDC_BA98, 32'h0,
               32'h0, 32'h0, 32'hFFFF_FFFF}));
    send_job(mk_job(AXIS_X, 32'h0002_0000, 12'd5,
             '{32'h0002_0000, 32'h1, 32'h2, 32'h0005_0000, 32'h3, 32'h4,
               32'h0007_0000, 32'h5, 32'h6}));
    send_job(mk_job(AXIS_Z, CMax, 12'd1,
             '{CMax, CMax, CMax, CMax, CMax, CMax, CMax, CMax, CMax}));
    send_job(mk_job(AXIS_X, CMin, 12'd2,
             '{CMin, CMin, CMin, CMin, CMin, CMin, CMin, CMin, CMin}));
    send_job(mk_job(AXIS_Y, 32'h7FFF_FFFE, 12'hFFF,
             '{CMin, CMax, CMin, CMax, CMin, CMax, CMin, CMin, CMax}));
    send_job(mk_job(AXIS_Z, CMin, 12'd6,
             '{CMax, CMax, CMin, CMin, CMin, CMax, CMax, CMin, 32'h0}));
    send_job(mk_job(AXIS_X, 32'hFFFF_FFFF, 12'd7,
             '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555,
               32'hFFFF_FFFE, 32'h8, 32'h9}));
    send_job(mk_job(AXIS_Y, 32'h0, 12'hFFF,
             '{32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'h7, 32'h8, 32'h9}));

    run_random(110, 1'b0);
    wait_drained();

    write_count(13'd4096);
    send_job(mk_job(AXIS_X, 32'h0, 12'd2000,
             '{CMin, 32'h0, 32'h0, CMax, 32'h0, 32'h0, CMax, 32'h1, 32'h1}));
    run_random(30, 1'b0);
    wait_drained();

    if (added <= 4093) write_count(CountW'(4093 - added));
    run_random(40, 1'b1);
    wait_drained();

    write_count(CountW'($urandom_range(0, 1000)));
    run_random(55, 1'b0);
    wait_drained();
    write_count('0);
    run_random(55, 1'b0);
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Run covered %0d input transactions and %0d result transactions,", n_in, n_out);
    $display("including %0d new splits and %0d memo replays.", n_split, n_replay);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
